// ===== hw/rtl/xud_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xud_pkg - shared types and constants for the unsigned divide unit
// Word layouts for the operand and result channels, status codes and the
// sizing of the divide pipeline.
// ----------------------------------------------------------------------------
package xud_pkg;

    // Widths of the architectural operands
    localparam int unsigned DIVIDEND_W = 32;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned QUO_W      = 16;
    localparam int unsigned BYTE_W     = 8;

    // Quotient bits resolved in each pipeline stage
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned NUM_STAGES      = QUO_W / STEPS_PER_STAGE;

    // Operand size codes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_WORD = 1'b1;

    // Completion status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    // Operand word
    typedef struct packed {
        logic                  mode;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [QUO_W-1:0] quotient;
        logic [QUO_W-1:0] remainder;
        status_t          status;
    } out_word_t;

endpackage

// ===== hw/rtl/x86_unsigned_divide_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_unsigned_divide_top - pipelined 8086 DIV unit
// Byte mode divides AX by an 8-bit source, word mode divides DX:AX by a
// 16-bit source. Divide by zero and quotient overflow are reported in status
// with zero quotient and remainder.
//
//   Channel   Handshake        Word        Direction
//   operand   start / busy     in_word_t   in
//   result    done (strobe)    out_word_t  out
//
// Results leave in the order their words were accepted; one word can be
// accepted every cycle, busy stays low.
// Latency is set by the 16 restoring steps, four per stage over four stages,
// plus an operand prep stage and the result register.
// Reset clears the stage valid bits and done only; data registers are not reset.
// The receiver cannot stall, so no word is ever held back inside the pipe.
// ----------------------------------------------------------------------------
module x86_unsigned_divide_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  xud_pkg::in_word_t operand,
    output logic              done,
    output xud_pkg::out_word_t result
);
    import xud_pkg::*;

    // Stage registers: index 0 is the prep stage, NUM_STAGES the last step stage
    logic                 valid_reg  [0:NUM_STAGES];
    logic [QUO_W-1:0]     rem_reg    [0:NUM_STAGES];
    logic [QUO_W-1:0]     low_reg    [0:NUM_STAGES];
    logic [DIVISOR_W-1:0] den_reg    [0:NUM_STAGES];
    status_t              status_reg [0:NUM_STAGES];

    // Output registers
    logic      done_reg;
    out_word_t result_reg;

    // Prep stage inputs
    logic                 accept;
    logic [QUO_W-1:0]     hi_next;
    logic [QUO_W-1:0]     rem_next;
    logic [DIVISOR_W-1:0] den_next;
    status_t              status_next;

    // The pipe never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Map byte mode onto the word engine: with DX forced to zero the first
    // eight steps only shift in AH, which is below the divisor when no
    // overflow is flagged.
    always_comb
    begin
        if (operand.mode == MODE_WORD)
        begin
            den_next = operand.divisor;
            hi_next  = operand.dividend[DIVIDEND_W-1:QUO_W];
            rem_next = operand.dividend[DIVIDEND_W-1:QUO_W];
        end
        else
        begin
            den_next = {{(DIVISOR_W-BYTE_W){1'b0}}, operand.divisor[BYTE_W-1:0]};
            hi_next  = {{(QUO_W-BYTE_W){1'b0}}, operand.dividend[QUO_W-1:BYTE_W]};
            rem_next = '0;
        end

        // Quotient fits only when the upper half is below the divisor
        if (den_next == '0)
            status_next = ST_DIV0;
        else if (hi_next >= den_next)
            status_next = ST_OVF;
        else
            status_next = ST_OK;
    end

    // Capture operands into the prep stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rem_reg[0]    <= rem_next;
            low_reg[0]    <= operand.dividend[QUO_W-1:0];
            den_reg[0]    <= den_next;
            status_reg[0] <= status_next;
        end
    end

    // Restoring divide stages, STEPS_PER_STAGE quotient bits each
    for (genvar g = 1; g <= NUM_STAGES; g++)
    begin : g_stage
        logic [QUO_W-1:0] rem_v;
        logic [QUO_W-1:0] low_v;
        logic [QUO_W:0]   trial;
        logic [QUO_W:0]   diff;

        // Shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            rem_v = rem_reg[g-1];
            low_v = low_reg[g-1];
            trial = '0;
            diff  = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                trial = {rem_v, low_v[QUO_W-1]};
                diff  = trial - {1'b0, den_reg[g-1]};
                low_v = {low_v[QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg[g-1]})
                begin
                    rem_v    = diff[QUO_W-1:0];
                    low_v[0] = 1'b1;
                end
                else
                begin
                    rem_v = trial[QUO_W-1:0];
                end
            end
        end

        // Advance valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else
                valid_reg[g] <= valid_reg[g-1];
        end

        // Advance stage data
        always_ff @(posedge clk)
        begin
            if (valid_reg[g-1])
            begin
                rem_reg[g]    <= rem_v;
                low_reg[g]    <= low_v;
                den_reg[g]    <= den_reg[g-1];
                status_reg[g] <= status_reg[g-1];
            end
        end
    end

    // Register the result, zeroed on any error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[NUM_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg[NUM_STAGES])
        begin
            result_reg.status <= status_reg[NUM_STAGES];
            if (status_reg[NUM_STAGES] == ST_OK)
            begin
                result_reg.quotient  <= low_reg[NUM_STAGES];
                result_reg.remainder <= rem_reg[NUM_STAGES];
            end
            else
            begin
                result_reg.quotient  <= '0;
                result_reg.remainder <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the pipelined 8086 DIV unit
// Drives operand words in byte and word mode through the start/busy
// handshake. A directed table covers the field extremes, divide by zero,
// quotient overflow and the ignored upper bits in byte mode. Random words
// follow, most of them built from a chosen quotient and remainder so that
// valid divides dominate. Every done strobe is checked field by field
// against an in-order queue of expected quotients, remainders and status.
// ----------------------------------------------------------------------------
module tb_top;

    import xud_pkg::*;

    localparam int unsigned PIPE_LATENCY = 6;
    localparam int unsigned RANDOM_PER_PHASE = 145;
    localparam int unsigned NUM_ROWS = 18;

    typedef struct {
        in_word_t  op;
        bit        fixed;
        out_word_t res;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  operand;
    logic      done;
    out_word_t result;

    out_word_t pending_results [$];
    int unsigned error_count;

    // Idle odds per phase, in percent: none, heavy, none, light
    int unsigned idle_pct [4] = '{0, 81, 0, 9};

    // Directed words; the expected word is typed in only where fixed is set
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{'{MODE_BYTE, 32'h0000_1234, 16'hFF00}, 1'b1, '{16'h0000, 16'h0000, ST_DIV0}},
        '{'{MODE_WORD, 32'hFFFF_FFFF, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, ST_DIV0}},
        '{'{MODE_BYTE, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{16'h0000, 16'h0000, ST_OVF}},
        '{'{MODE_BYTE, 32'hABCD_00FF, 16'hFF01}, 1'b1, '{16'h00FF, 16'h0000, ST_OK}},
        '{'{MODE_BYTE, 32'h0000_0100, 16'h0001}, 1'b1, '{16'h0000, 16'h0000, ST_OVF}},
        '{'{MODE_BYTE, 32'h0000_FEFF, 16'h00FF}, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_BYTE, 32'h0000_0000, 16'h00FF}, 1'b1, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_BYTE, 32'h5555_7FFF, 16'h0080}, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_BYTE, 32'h0000_00FE, 16'h00FF}, 1'b1, '{16'h0000, 16'h00FE, ST_OK}},
        '{'{MODE_WORD, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{16'h0000, 16'h0000, ST_OVF}},
        '{'{MODE_WORD, 32'hFFFE_FFFF, 16'hFFFF}, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_WORD, 32'h0000_0000, 16'h0001}, 1'b1, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_WORD, 32'h0001_0000, 16'h0001}, 1'b1, '{16'h0000, 16'h0000, ST_OVF}},
        '{'{MODE_WORD, 32'h0000_FFFF, 16'h0001}, 1'b1, '{16'hFFFF, 16'h0000, ST_OK}},
        '{'{MODE_WORD, 32'h1234_5678, 16'hFFFF}, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_WORD, 32'h7FFF_FFFF, 16'h8000}, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_WORD, 32'h0003_0007, 16'h0004}, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{'{MODE_WORD, 32'h0000_FFFE, 16'hFFFF}, 1'b1, '{16'h0000, 16'hFFFE, ST_OK}}
    };

    x86_unsigned_divide_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    // Free-running clock, 20 ns period
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Work out the DIV outcome: quotient and remainder, or a fault status
    function automatic out_word_t divide_8086(in_word_t w);
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] qmax;
        logic [31:0] q_full;
        out_word_t   r;
        r.quotient  = '0;
        r.remainder = '0;
        r.status    = ST_OK;
        if (w.mode == MODE_BYTE)
        begin
            num  = {16'h0000, w.dividend[15:0]};
            den  = {24'h000000, w.divisor[7:0]};
            qmax = 32'h0000_00FF;
        end
        else
        begin
            num  = w.dividend;
            den  = {16'h0000, w.divisor};
            qmax = 32'h0000_FFFF;
        end
        if (den == 0)
            r.status = ST_DIV0;
        else
        begin
            q_full = num / den;
            if (q_full > qmax)
                r.status = ST_OVF;
            else
            begin
                r.quotient  = q_full[15:0];
                r.remainder = 16'(num % den);
            end
        end
        return r;
    endfunction

    // Draw an operand word: mostly in-range divides, some zero divisors and raw noise
    function automatic in_word_t random_divide();
        in_word_t    w;
        int unsigned pick;
        bit [31:0]   d;
        bit [31:0]   q;
        bit [31:0]   rem;
        bit [31:0]   junk;
        pick   = $urandom_range(99);
        junk   = $urandom();
        w.mode = ($urandom_range(1) == 0) ? MODE_BYTE : MODE_WORD;
        if (pick < 10)
        begin
            w.dividend = $urandom();
            w.divisor  = (w.mode == MODE_BYTE) ? {junk[7:0], 8'h00} : 16'h0000;
        end
        else if (pick < 30)
        begin
            w.dividend = $urandom();
            w.divisor  = junk[15:0];
        end
        else if (w.mode == MODE_BYTE)
        begin
            d   = $urandom_range(255, 1);
            q   = $urandom_range(255);
            rem = $urandom_range(d - 1);
            w.dividend = {junk[31:16], 16'(q * d + rem)};
            w.divisor  = {junk[15:8], d[7:0]};
        end
        else
        begin
            d   = (pick < 45) ? $urandom_range(15, 1) : $urandom_range(65535, 1);
            q   = $urandom_range(65535);
            rem = $urandom_range(d - 1);
            w.dividend = q * d + rem;
            w.divisor  = d[15:0];
        end
        return w;
    endfunction

    // Hold one word on the operand port until taken; queue its expected result
    task automatic send_word(in_word_t w, out_word_t exp_res);
        start   <= 1'b1;
        operand <= w;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                pending_results.push_back(exp_res);
                break;
            end
        end
        @(negedge clk);
    endtask

    // Drop start for a random stretch of cycles
    task automatic idle_gap(int unsigned pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        out_word_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: q=%h r=%h st=%0d",
                       result.quotient, result.remainder, result.status);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result.quotient !== exp_res.quotient)
                begin
                    $error("quotient: expected %h, actual %h",
                           exp_res.quotient, result.quotient);
                    error_count++;
                end
                if (result.remainder !== exp_res.remainder)
                begin
                    $error("remainder: expected %h, actual %h",
                           exp_res.remainder, result.remainder);
                    error_count++;
                end
                if (result.status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_res.status, result.status);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial
    begin
        in_word_t    w;
        int unsigned wait_cycles;
        error_count = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].fixed)
                send_word(directed_rows[i].op, directed_rows[i].res);
            else
                send_word(directed_rows[i].op, divide_8086(directed_rows[i].op));
        end

        // Random words under each idle pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                idle_gap(idle_pct[ph]);
                w = random_divide();
                send_word(w, divide_8086(w));
            end
        end
        start <= 1'b0;

        // Drain the pipe, bounded
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/xud_pkg.sv
hw/rtl/x86_unsigned_divide_top.sv
verif/tb_top.sv
